### src/abrf_pkg.sv
package abrf_pkg;

    localparam int NUM_BANKS_DEF  = 4;
    localparam int BANK_BYTES     = 8;
    localparam int VIEWS_PER_BANK = 15;
    localparam int BANK_W         = 5;   // register number / 15 reaches 17
    localparam int ROW_W          = 8 * BANK_BYTES;

    // reciprocal of 15 scaled by 2^11, exact for every 8-bit register number
    localparam logic [7:0] RECIP_15   = 8'd137;
    localparam int         RECIP_SHIFT = 11;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [3:0] VIEW_LAST_BYTE = 4'd7;
    localparam logic [3:0] VIEW_LAST_PAIR = 4'd11;
    localparam logic [3:0] VIEW_LAST_QUAD = 4'd13;
    localparam logic [3:0] VIEW_PAIR_BASE = 4'd8;
    localparam logic [3:0] VIEW_QUAD_BASE = 4'd12;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [2:0]        first;
        logic [3:0]        len;
    } access_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  reg_number;
        logic [63:0] write_value;
    } req_t;

    // first byte and byte count of a view, most significant byte first
    function automatic logic [6:0] view_span(input logic [3:0] view);
        logic [3:0] rel;
        logic [2:0] first;
        logic [3:0] len;
        begin
            rel = 4'd0;
            if (view <= VIEW_LAST_BYTE)
            begin
                first = view[2:0];
                len   = 4'd1;
            end
            else if (view <= VIEW_LAST_PAIR)
            begin
                rel   = view - VIEW_PAIR_BASE;
                first = {rel[1:0], 1'b0};
                len   = 4'd2;
            end
            else if (view <= VIEW_LAST_QUAD)
            begin
                rel   = view - VIEW_QUAD_BASE;
                first = {rel[0], 2'b00};
                len   = 4'd4;
            end
            else
            begin
                first = 3'd0;
                len   = 4'd8;
            end
            return {first, len};
        end
    endfunction

endpackage

### src/abrf_if.sv
interface abrf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  reg_number;
    logic [63:0] write_value;

    modport source (output valid, output mode, output reg_number, output write_value,
                    input ready);
    modport sink (input valid, input mode, input reg_number, input write_value,
                  output ready);
endinterface

interface abrf_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [3:0]  size_bytes;

    modport source (output valid, output read_data, output size_bytes, input ready);
    modport sink (input valid, input read_data, input size_bytes, output ready);
endinterface

### src/aliased_byte_register_file_top.sv
// Channel | Dir | Payload
// req     | in  | mode[1:0], reg_number[7:0], write_value[63:0]
// rsp     | out | read_data[63:0], size_bytes[3:0]
//
// One item per cycle unless rsp stalls; stage one feeds the result register.
// Stage one holds the request; decode, bank read and bank write happen on its way
// into the result register, so a read sees every earlier write.
// rst_n clears all banks and both stage valids at once; no clearing pass.
// A stalled rsp holds the result register, then the request stage, then req.ready.
module aliased_byte_register_file_top #(
    parameter int NUM_BANKS = abrf_pkg::NUM_BANKS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    abrf_req_if.sink  req,
    abrf_rsp_if.source rsp
);

    abrf_pkg::req_t    s1_reg;
    logic              s1_valid_reg;
    logic              out_valid_reg;
    logic [63:0]       read_data_reg;
    logic [3:0]        size_reg;
    logic              out_advance;
    logic              s1_fire;
    abrf_pkg::access_t acc;
    logic [63:0]       rd;

    assign out_advance = !out_valid_reg || rsp.ready;
    assign s1_fire     = s1_valid_reg && out_advance;
    assign req.ready   = !s1_valid_reg || out_advance;

    abrf_decode u_decode (
        .reg_number (s1_reg.reg_number),
        .acc        (acc)
    );

    abrf_store #(
        .NUM_BANKS (NUM_BANKS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .mode        (s1_reg.mode),
        .acc         (acc),
        .write_value (s1_reg.write_value),
        .read_data   (rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_reg.mode        <= req.mode;
            s1_reg.reg_number  <= req.reg_number;
            s1_reg.write_value <= req.write_value;
        end
        if (s1_fire)
        begin
            read_data_reg <= rd;
            size_reg      <= acc.len;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_data  = read_data_reg;
    assign rsp.size_bytes = size_reg;

    a_size_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> $onehot(rsp.size_bytes))
        else $error("view size is not 1, 2, 4 or 8");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("request stage advanced without filling result");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg && !rsp.ready))
        else $error("input stalled with room in the pipeline");

    a_read_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.size_bytes != 4'd8) |-> (rsp.read_data[63:32] == 32'd0))
        else $error("read data wider than its view");

endmodule

### src/abrf_decode.sv
module abrf_decode (
    input  logic [7:0]       reg_number,
    output abrf_pkg::access_t acc
);

    logic [15:0] prod;
    logic [abrf_pkg::BANK_W-1:0] bank;
    logic [7:0]  bank_base;
    logic [3:0]  view;
    logic [6:0]  span;

    // bank = number / 15 through the reciprocal, view is what remains
    assign prod      = 16'(reg_number) * 16'(abrf_pkg::RECIP_15);
    assign bank      = prod[abrf_pkg::RECIP_SHIFT +: abrf_pkg::BANK_W];
    assign bank_base = 8'(bank) * 8'(abrf_pkg::VIEWS_PER_BANK);
    assign view      = 4'(reg_number - bank_base);
    assign span      = abrf_pkg::view_span(view);

    assign acc.bank  = bank;
    assign acc.first = span[6:4];
    assign acc.len   = span[3:0];

endmodule

### src/abrf_store.sv
module abrf_store #(
    parameter int NUM_BANKS = abrf_pkg::NUM_BANKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [1:0]        mode,
    input  abrf_pkg::access_t acc,
    input  logic [63:0]       write_value,
    output logic [63:0]       read_data
);

    localparam int IDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

    // byte 0 of a bank sits in the top byte of its row
    logic [abrf_pkg::ROW_W-1:0] rows_reg [NUM_BANKS];
    logic [abrf_pkg::ROW_W-1:0] row;
    logic [abrf_pkg::ROW_W-1:0] row_next;
    logic [IDX_W-1:0]           idx;
    logic                       bank_ok;
    logic [5:0]                 rd_shift;
    logic [63:0]                rd_mask;
    logic [3:0]                 last;

    assign bank_ok = acc.bank < abrf_pkg::BANK_W'(NUM_BANKS);
    assign idx     = acc.bank[IDX_W-1:0];
    assign row     = bank_ok ? rows_reg[idx] : '0;
    assign last    = 4'(acc.first) + acc.len;   // one past the last byte

    always_comb
    begin
        rd_shift = {3'(4'd8 - last), 3'b000};
        rd_mask  = (acc.len == 4'd8) ? '1 : ((64'd1 << (6'(acc.len) * 6'd8)) - 64'd1);
        read_data = (mode == abrf_pkg::MODE_READ) ? ((row >> rd_shift) & rd_mask) : '0;
    end

    always_comb
    begin
        logic [3:0] off;
        logic [5:0] sh;
        row_next = row;
        for (int i = 0; i < abrf_pkg::BANK_BYTES; i++)
        begin
            off = 4'(i) - 4'(acc.first);
            sh  = {3'(acc.len - 4'd1 - off), 3'b000};
            if (4'(i) >= 4'(acc.first) && 4'(i) < last)
                row_next[(abrf_pkg::ROW_W - 8 - 8 * i) +: 8] = 8'(write_value >> sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
                rows_reg[b] <= '0;
        end
        else if (fire)
        begin
            if (mode == abrf_pkg::MODE_CLEAR)
            begin
                for (int b = 0; b < NUM_BANKS; b++)
                    rows_reg[b] <= '0;
            end
            else if (mode == abrf_pkg::MODE_WRITE && bank_ok)
            begin
                rows_reg[idx] <= row_next;
            end
        end
    end

endmodule
